// ----- design/button_gesture_sequencer_assert.svh -----
// Assertion macros shared by the button gesture sequencer.
`ifndef BUTTON_GESTURE_SEQUENCER_ASSERT_SVH
`define BUTTON_GESTURE_SEQUENCER_ASSERT_SVH

// Same-cycle implication, checked on aclk while out of reset.
`define BGS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on aclk while out of reset.
`define BGS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/bgs_pkg.sv -----
// Types, codes and reset values shared by the button gesture sequencer.
package bgs_pkg;

    // Request codes of the req_type field.
    localparam logic [2:0] REQ_TICK      = 3'd0;
    localparam logic [2:0] REQ_POWER_ON  = 3'd1;
    localparam logic [2:0] REQ_TOGGLE    = 3'd2;
    localparam logic [2:0] REQ_POWER_OFF = 3'd3;
    localparam logic [2:0] REQ_ABORT     = 3'd4;
    localparam logic [2:0] REQ_OVERRIDE  = 3'd5;

    // Response status codes.
    localparam logic [1:0] RS_ACCEPTED = 2'd0;
    localparam logic [1:0] RS_BUSY     = 2'd1;
    localparam logic [1:0] RS_REJECTED = 2'd2;
    localparam logic [1:0] RS_NONE     = 2'd3;

    // Assumed device states.
    localparam logic [1:0] ST_OFF  = 2'd0;
    localparam logic [1:0] ST_IDLE = 2'd1;
    localparam logic [1:0] ST_REC  = 2'd2;

    // Gesture kinds.
    localparam logic [1:0] GK_NONE      = 2'd0;
    localparam logic [1:0] GK_POWER_ON  = 2'd1;
    localparam logic [1:0] GK_TOGGLE    = 2'd2;
    localparam logic [1:0] GK_POWER_OFF = 2'd3;

    // Configuration register indexes.
    localparam logic [2:0] CFG_SHORT_PRESS = 3'd0;
    localparam logic [2:0] CFG_LONG_PRESS  = 3'd1;
    localparam logic [2:0] CFG_BOOT_PRESS  = 3'd2;
    localparam logic [2:0] CFG_GUARD_GAP   = 3'd3;

    // Configuration reset values in milliseconds.
    localparam logic [15:0] SHORT_PRESS_RST = 16'd200;
    localparam logic [15:0] LONG_PRESS_RST  = 16'd3000;
    localparam logic [15:0] BOOT_PRESS_RST  = 16'd3000;
    localparam logic [15:0] GUARD_GAP_RST   = 16'd500;

    // Gesture phase.
    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_ASSERT  = 2'd1,
        PH_HOLD    = 2'd2,
        PH_RELEASE = 2'd3
    } phase_t;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [31:0] now_ms;
        logic        press_ok;
        logic [1:0]  new_state;
    } in_item_t;

    typedef struct packed {
        logic [1:0] status;
        logic       noop;
        logic       button_level;
        logic       busy_flag;
        logic [1:0] device_state;
        logic       done_res;
        logic [1:0] done_gesture;
    } out_item_t;

    typedef struct packed {
        logic [15:0] short_press_ms;
        logic [15:0] long_press_ms;
        logic [15:0] power_on_hold_ms;
        logic [15:0] guard_gap_ms;
    } cfg_t;

    // Handshake status between the pipeline stages.
    typedef struct packed {
        logic in_vld;
        logic out_free;
    } stage_ctl_t;

endpackage

// ----- design/bgs_cfg_regs.sv -----
// Configuration register file of the button gesture sequencer.
module bgs_cfg_regs (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [2:0]    cfg_index,
    input  logic [15:0]   cfg_data,
    output bgs_pkg::cfg_t cfg
);
    import bgs_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // The register file takes a word in every cycle.
    assign cfg_ready = 1'b1;

    // Decode the written index; unknown indexes are dropped.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_SHORT_PRESS: cfg_next.short_press_ms   = cfg_data;
                CFG_LONG_PRESS:  cfg_next.long_press_ms    = cfg_data;
                CFG_BOOT_PRESS:  cfg_next.power_on_hold_ms = cfg_data;
                CFG_GUARD_GAP:   cfg_next.guard_gap_ms     = cfg_data;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.short_press_ms   <= SHORT_PRESS_RST;
            cfg_reg.long_press_ms    <= LONG_PRESS_RST;
            cfg_reg.power_on_hold_ms <= BOOT_PRESS_RST;
            cfg_reg.guard_gap_ms     <= GUARD_GAP_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- design/bgs_in_stage.sv -----
// Input register stage holding one request word.
module bgs_in_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  bgs_pkg::in_item_t s_item,
    input  logic              take,
    output logic              vld,
    output bgs_pkg::in_item_t item
);
    import bgs_pkg::*;

    logic     vld_reg;
    logic     vld_next;
    in_item_t item_reg;
    logic     accept;

    // Room whenever the stage is empty or being drained this cycle.
    assign s_ready  = !vld_reg || take;
    assign accept   = s_valid && s_ready;
    assign vld_next = accept || (vld_reg && !take);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= s_item;
        end
    end

    assign vld  = vld_reg;
    assign item = item_reg;

endmodule

// ----- design/bgs_core.sv -----
// Gesture state machine: decides on one request word and updates the state.
module bgs_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  bgs_pkg::cfg_t      cfg,
    input  bgs_pkg::in_item_t  item,
    input  logic               go,
    output bgs_pkg::out_item_t result
);
    import bgs_pkg::*;

    logic        in_flight_reg, in_flight_next;
    phase_t      phase_reg, phase_next;
    logic        pressed_reg, pressed_next;
    logic [31:0] deadline_reg, deadline_next;
    logic [31:0] guard_until_reg, guard_until_next;
    logic [15:0] hold_time_reg, hold_time_next;
    logic        update_pending_reg, update_pending_next;
    logic [1:0]  next_state_reg, next_state_next;
    logic [1:0]  assumed_reg, assumed_next;
    logic [1:0]  active_kind_reg, active_kind_next;

    logic [1:0]  status;
    logic        noop;
    logic        start;
    logic [1:0]  start_kind;
    logic [15:0] start_hold;
    logic [1:0]  start_target;
    logic        tick_due;
    logic        in_guard;
    logic        is_on;
    logic        done;
    logic        abort;
    logic [31:0] abort_time;

    assign in_guard   = item.now_ms < guard_until_reg;
    assign is_on      = (assumed_reg == ST_IDLE) || (assumed_reg == ST_REC);
    assign tick_due   = (item.req_type == REQ_TICK) && in_flight_reg
                        && (item.now_ms >= deadline_reg);
    assign abort_time = deadline_reg + {16'd0, cfg.guard_gap_ms};

    // Answer gesture requests and pick the gesture to start.
    always_comb begin
        status       = RS_NONE;
        noop         = 1'b0;
        start        = 1'b0;
        start_kind   = GK_NONE;
        start_hold   = 16'd0;
        start_target = ST_OFF;
        case (item.req_type)
            REQ_POWER_ON: begin
                if (in_flight_reg) begin
                    status = RS_BUSY;
                end else if (is_on) begin
                    status = RS_ACCEPTED;
                    noop   = 1'b1;
                end else if (in_guard) begin
                    status = RS_BUSY;
                end else begin
                    status       = RS_ACCEPTED;
                    start        = 1'b1;
                    start_kind   = GK_POWER_ON;
                    start_hold   = cfg.power_on_hold_ms;
                    start_target = ST_IDLE;
                end
            end
            REQ_TOGGLE: begin
                if (in_flight_reg) begin
                    status = RS_BUSY;
                end else if (assumed_reg == ST_OFF) begin
                    status = RS_REJECTED;
                end else if (in_guard) begin
                    status = RS_BUSY;
                end else begin
                    status       = RS_ACCEPTED;
                    start        = 1'b1;
                    start_kind   = GK_TOGGLE;
                    start_hold   = cfg.short_press_ms;
                    start_target = (assumed_reg == ST_REC) ? ST_IDLE : ST_REC;
                end
            end
            REQ_POWER_OFF: begin
                if (in_flight_reg) begin
                    status = RS_BUSY;
                end else if (assumed_reg == ST_OFF) begin
                    status = RS_ACCEPTED;
                    noop   = 1'b1;
                end else if (in_guard) begin
                    status = RS_BUSY;
                end else begin
                    status       = RS_ACCEPTED;
                    start        = 1'b1;
                    start_kind   = GK_POWER_OFF;
                    start_hold   = cfg.long_press_ms;
                    start_target = ST_OFF;
                end
            end
            default: begin
                status = RS_NONE;
            end
        endcase
    end

    // Next state of the gesture sequencer.
    always_comb begin
        in_flight_next      = in_flight_reg;
        phase_next          = phase_reg;
        pressed_next        = pressed_reg;
        deadline_next       = deadline_reg;
        guard_until_next    = guard_until_reg;
        hold_time_next      = hold_time_reg;
        update_pending_next = update_pending_reg;
        next_state_next     = next_state_reg;
        assumed_next        = assumed_reg;
        active_kind_next    = active_kind_reg;
        abort               = 1'b0;
        done                = 1'b0;

        case (item.req_type)
            REQ_TICK: begin
                if (tick_due) begin
                    case (phase_reg)
                        PH_ASSERT: begin
                            if (!item.press_ok) begin
                                abort = 1'b1;
                            end else begin
                                pressed_next  = 1'b1;
                                phase_next    = PH_HOLD;
                                deadline_next = item.now_ms + {16'd0, hold_time_reg};
                            end
                        end
                        PH_HOLD: begin
                            phase_next    = PH_RELEASE;
                            deadline_next = item.now_ms;
                        end
                        PH_RELEASE: begin
                            pressed_next = 1'b0;
                            if (update_pending_reg) begin
                                assumed_next        = next_state_reg;
                                update_pending_next = 1'b0;
                            end
                            guard_until_next = item.now_ms + {16'd0, cfg.guard_gap_ms};
                            in_flight_next   = 1'b0;
                            phase_next       = PH_IDLE;
                            active_kind_next = GK_NONE;
                            hold_time_next   = 16'd0;
                            done             = 1'b1;
                        end
                        default: begin
                            abort = 1'b1;
                        end
                    endcase
                end
            end
            REQ_ABORT: begin
                abort = 1'b1;
            end
            REQ_OVERRIDE: begin
                if (item.new_state <= ST_REC) begin
                    assumed_next = item.new_state;
                end
            end
            default: begin
                if (start) begin
                    in_flight_next      = 1'b1;
                    phase_next          = PH_ASSERT;
                    active_kind_next    = start_kind;
                    hold_time_next      = start_hold;
                    update_pending_next = 1'b1;
                    next_state_next     = start_target;
                    deadline_next       = item.now_ms;
                end
            end
        endcase

        // An abort releases the button and arms the guard from the deadline.
        if (abort) begin
            pressed_next        = 1'b0;
            in_flight_next      = 1'b0;
            phase_next          = PH_IDLE;
            active_kind_next    = GK_NONE;
            hold_time_next      = 16'd0;
            update_pending_next = 1'b0;
            guard_until_next    = abort_time;
            deadline_next       = abort_time;
        end
    end

    // Result word reflects the state after this request.
    always_comb begin
        result.status       = status;
        result.noop         = noop;
        result.button_level = pressed_next;
        result.busy_flag    = in_flight_next;
        result.device_state = assumed_next;
        result.done_res     = done;
        result.done_gesture = done ? active_kind_reg : GK_NONE;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_flight_reg      <= 1'b0;
            phase_reg          <= PH_IDLE;
            pressed_reg        <= 1'b0;
            deadline_reg       <= 32'd0;
            guard_until_reg    <= 32'd0;
            hold_time_reg      <= 16'd0;
            update_pending_reg <= 1'b0;
            next_state_reg     <= ST_OFF;
            assumed_reg        <= ST_OFF;
            active_kind_reg    <= GK_NONE;
        end else if (go) begin
            in_flight_reg      <= in_flight_next;
            phase_reg          <= phase_next;
            pressed_reg        <= pressed_next;
            deadline_reg       <= deadline_next;
            guard_until_reg    <= guard_until_next;
            hold_time_reg      <= hold_time_next;
            update_pending_reg <= update_pending_next;
            next_state_reg     <= next_state_next;
            assumed_reg        <= assumed_next;
            active_kind_reg    <= active_kind_next;
        end
    end

endmodule

// ----- design/bgs_out_stage.sv -----
// Result register stage holding one response word.
module bgs_out_stage (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               load,
    input  bgs_pkg::out_item_t d,
    output logic               free,
    output logic               m_valid,
    input  logic               m_ready,
    output bgs_pkg::out_item_t m_item
);
    import bgs_pkg::*;

    logic      vld_reg;
    logic      vld_next;
    out_item_t item_reg;

    // The register can load when empty or when its word leaves this cycle.
    assign free     = !vld_reg || m_ready;
    assign vld_next = load || (vld_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            item_reg <= d;
        end
    end

    assign m_valid = vld_reg;
    assign m_item  = item_reg;

endmodule

// ----- design/button_gesture_sequencer.sv -----
// Top level of the button gesture sequencer.
//
// Request words enter on the s_ channel (valid/ready) and each produces
// exactly one response word on the m_ channel (valid/ready), in order.
// Configuration words enter on the cfg_ channel; cfg_ready is always high
// and a write takes effect on the next cycle. Write it only while idle.
// A word accepted into the input register is evaluated by the gesture
// state machine once the result register has room, and its response is
// then captured in the result register, which raises m_valid.
// One word per cycle is sustained while m_ready is high; the state update
// is one pass of compares and 32-bit adds from input to result register.
// When the receiver stalls, the result register holds its word, the input
// register keeps one more, and s_ready falls once both are full.
// Reset (aresetn low, synchronous) empties both stages, releases the
// button, ends any gesture, sets the assumed state to off and restores
// the default hold and guard times.
`include "button_gesture_sequencer_assert.svh"

module button_gesture_sequencer (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  bgs_pkg::in_item_t  s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output bgs_pkg::out_item_t m_item,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data
);
    import bgs_pkg::*;

    cfg_t       cfg;
    in_item_t   in_item;
    out_item_t  core_result;
    stage_ctl_t ctl;
    logic       go;
    logic       res_pressed_ok;
    logic       res_done;
    logic       res_done_ok;
    logic       res_noop;
    logic       res_accepted;

    bgs_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bgs_in_stage u_in (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .take    (go),
        .vld     (ctl.in_vld),
        .item    (in_item)
    );

    // A word is evaluated when present and the result register has room.
    assign go = ctl.in_vld && ctl.out_free;

    bgs_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .item    (in_item),
        .go      (go),
        .result  (core_result)
    );

    bgs_out_stage u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (go),
        .d       (core_result),
        .free    (ctl.out_free),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    // Terms of the result word used by the checks below.
    assign res_pressed_ok = !m_item.button_level || m_item.busy_flag;
    assign res_done       = m_valid && m_item.done_res;
    assign res_done_ok    = !m_item.busy_flag && (m_item.done_gesture != GK_NONE);
    assign res_noop       = m_valid && m_item.noop;
    assign res_accepted   = m_item.status == RS_ACCEPTED;

    // The button is never held down outside a gesture.
    `BGS_ASSERT_NOW(a_press_in_flight, m_valid, res_pressed_ok, "button pressed with no gesture")
    // A completion ends the gesture and names a real gesture.
    `BGS_ASSERT_NOW(a_done_ends_flight, res_done, res_done_ok, "bad gesture completion")
    // A no-op answer only comes with an accepted status.
    `BGS_ASSERT_NOW(a_noop_accepted, res_noop, res_accepted, "no-op without accepted status")
    // A waiting request word is not lost while the result side is full.
    `BGS_ASSERT_NEXT(a_in_word_kept, ctl.in_vld && !go, ctl.in_vld, "input word dropped")

endmodule
